[design/ilb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_pkg: shared definitions for the insertable list buffer
// Field widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package ilb_pkg;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// operation codes carried by kind
	localparam logic [KIND_W-1:0] OP_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] OP_POP    = 3'd1;
	localparam logic [KIND_W-1:0] OP_INSERT = 3'd2;
	localparam logic [KIND_W-1:0] OP_ERASE  = 3'd3;
	localparam logic [KIND_W-1:0] OP_READ   = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_WR   = 5'b00100,
		S_FIN  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

endpackage

[design/insertable_list_buffer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertable_list_buffer_core: fixed-capacity ordered list of signed words
// Append, remove last, insert or erase at a position, and read one entry,
// with entries moved one at a time through a single-port word memory.
// ----------------------------------------------------------------------------
//
//  channel   signals                                         direction
//  item      item_valid, item_ready, kind, value, position   in
//  result    result_valid, result_ready, status, read_value,  out
//            count, is_empty, free_slots
//
//  Append, remove last, refused and unused operations go from accept
//  straight to the output state S_OUT; read passes S_RD and S_WR first.
//  Insert and erase take one memory read step S_RD and one write step S_WR
//  per moved entry, then S_FIN. item_ready is high only while the
//  sequencer is idle; one result register sits on the output, so a new item
//  is taken while a result waits, and the next one waits for result_ready.
//  Reset clears the count and control; memory contents are not cleared.
//
module insertable_list_buffer_core #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic [ilb_pkg::KIND_W-1:0]           kind,
	input  logic signed [ilb_pkg::VALUE_W-1:0]   value,
	input  logic [ilb_pkg::POS_W-1:0]            position,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [ilb_pkg::STATUS_W-1:0]         status,
	output logic signed [ilb_pkg::VALUE_W-1:0]   read_value,
	output logic [ilb_pkg::COUNT_W-1:0]          count,
	output logic                                 is_empty,
	output logic [ilb_pkg::COUNT_W-1:0]          free_slots
);
	import ilb_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
	localparam logic [XW-1:0] ONE_X = XW'(1);
	localparam logic [XW-1:0] TWO_X = XW'(2);

	// word memory
	logic [VALUE_W-1:0] mem [CAPACITY];

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [XW-1:0]      idx_q;
	logic [KIND_W-1:0]  kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [XW-1:0]      pos_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0] rv_q;
	logic [VALUE_W-1:0] rd_q;

	logic [XW-1:0]      count_x;
	logic [XW-1:0]      pos_x;
	logic               full;
	logic               pos_bad;
	logic [STATUS_W-1:0] status_d;
	logic               accept;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;
	logic [XW-1:0]      rd_idx;
	logic               out_free;

	logic [XW-1:0]      res_count_x;

	assign count_x    = XW'(count_q);
	assign pos_x      = XW'(position);
	assign full       = (count_x >= CAP_X);
	assign pos_bad    = (pos_x >= count_x);
	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid || result_ready;

	// check the incoming operation against the current count
	always_comb begin
		status_d = ST_OK;
		unique case (kind)
			OP_APPEND: if (full) status_d = ST_FULL;
			OP_POP:    if (count_q == '0) status_d = ST_EMPTY;
			OP_INSERT: begin
				if (pos_bad) status_d = ST_RANGE;
				else if (full) status_d = ST_FULL;
			end
			OP_ERASE:  if (pos_bad) status_d = ST_RANGE;
			OP_READ:   if (pos_bad) status_d = ST_RANGE;
			default:   status_d = ST_OK;
		endcase
	end

	// pick the memory read address for the current move
	always_comb begin
		unique case (kind_q)
			OP_INSERT: rd_idx = idx_q - ONE_X;
			OP_ERASE:  rd_idx = idx_q + ONE_X;
			default:   rd_idx = idx_q;
		endcase
	end
	assign rd_addr = rd_idx[AW-1:0];

	// steer the single write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		if (accept && kind == OP_APPEND && status_d == ST_OK) begin
			wr_en   = 1'b1;
			wr_addr = count_x[AW-1:0];
			wr_data = value;
		end else if (state_q == S_WR && (kind_q == OP_INSERT || kind_q == OP_ERASE)) begin
			wr_en = 1'b1;
		end else if (state_q == S_FIN && kind_q == OP_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = pos_q[AW-1:0];
			wr_data = value_q;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (state_q == S_RD) rd_q <= mem[rd_addr];
	end

	// hold the item fields for the sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			value_q  <= value;
			pos_q    <= pos_x;
			status_q <= status_d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rv_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rv_q    <= '0;
						state_q <= S_OUT;
						if (status_d == ST_OK) begin
							unique case (kind)
								OP_APPEND: count_q <= count_q + 1'b1;
								OP_POP:    count_q <= count_q - 1'b1;
								OP_INSERT: begin
									idx_q   <= count_x;
									state_q <= S_RD;
								end
								OP_ERASE: begin
									idx_q <= pos_x;
									if (pos_x + ONE_X < count_x) state_q <= S_RD;
									else state_q <= S_FIN;
								end
								OP_READ: begin
									idx_q   <= pos_x;
									state_q <= S_RD;
								end
								default: state_q <= S_OUT;
							endcase
						end
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					unique case (kind_q)
						OP_INSERT: begin
							idx_q <= idx_q - ONE_X;
							if (idx_q - ONE_X == pos_q) state_q <= S_FIN;
							else state_q <= S_RD;
						end
						OP_ERASE: begin
							idx_q <= idx_q + ONE_X;
							if (idx_q + TWO_X < count_x) state_q <= S_RD;
							else state_q <= S_FIN;
						end
						default: begin
							rv_q    <= rd_q;
							state_q <= S_OUT;
						end
					endcase
				end
				S_FIN: begin
					if (kind_q == OP_INSERT) count_q <= count_q + 1'b1;
					else count_q <= count_q - 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	assign res_count_x = XW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			status     <= status_q;
			read_value <= rv_q;
			count      <= res_count_x[COUNT_W-1:0];
			is_empty   <= (count_q == '0);
			free_slots <= COUNT_W'(CAP_X - res_count_x);
		end
	end

	// count never exceeds the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= CAP_X)
		else $error("list count above capacity");

	// the read step S_RD is always followed by the write step S_WR
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |=> state_q == S_WR)
		else $error("read step not followed by write step");

	// an insert move never walks below the insert position
	a_insert_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && kind_q == OP_INSERT) |-> idx_q > pos_q)
		else $error("insert shift index below position");

	// a shift sequence only runs with entries present
	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> count_q != '0)
		else $error("shift sequence on empty list");

endmodule
